@@ rtl/core/accumulated_pixel_resolve_assert.svh @@
// assertion macros for the pixel resolve block
`ifndef ACCUMULATED_PIXEL_RESOLVE_ASSERT_SVH
`define ACCUMULATED_PIXEL_RESOLVE_ASSERT_SVH

`define APR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define APR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/apr_pkg.sv @@
// constants and types for the pixel resolve block
`default_nettype none
package apr_pkg;
  localparam int unsigned SUM_FRAC_BITS = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SQ_W    = 2 * BYTE_W;
  localparam int unsigned FULL_W  = 16;
  localparam logic [FULL_W-1:0] FULL_SCALE_SQ = 16'd65025;
  localparam int unsigned PROD_W  = SUM_W + FULL_W;
  localparam int unsigned RHS_W   = PROD_W - SUM_FRAC_BITS;
  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned NUM_STG = BYTE_W;
  localparam int unsigned IN_W    = 3 * SUM_W + CNT_W;
  localparam int unsigned OUT_W   = 3 * BYTE_W;

  typedef struct packed {
    logic [RHS_W-1:0]  rhs;
    logic [SQ_W-1:0]   sq;
    logic [BYTE_W-1:0] k;
  } chan_t;
endpackage
`default_nettype wire

@@ rtl/core/accumulated_pixel_resolve.sv @@
// pixel resolve top level: mean, square root and byte scaling in a 9-stage pipeline
//
//  channel  dir  tdata fields (lsb first)                          tuser  tlast
//  s_axis   in   sum_red[31:0] sum_green sum_blue sample_count[15:0]  -      -
//  m_axis   out  out_red[7:0] out_green out_blue                   -      -
//
// one pixel per cycle while m_axis is not stalled; the last stage feeds the output register
// one stage forms the scaled sum, eight stages each fix one output bit
// with a 16x16 multiply and compare
// rst_ni clears the valid bits only
// a stall on m_axis holds every stage; s_axis_tready follows it the same cycle
`default_nettype none
module accumulated_pixel_resolve import apr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output      logic             s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,  // sum_red, sum_green, sum_blue, sample_count
  output      logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output      logic [OUT_W-1:0] m_axis_tdata   // out_red, out_green, out_blue
);
  logic               adv;
  logic               vld_q  [NUM_STG+1];
  logic               zero_q [NUM_STG+1];
  logic [CNT_W-1:0]   cnt_q  [NUM_STG+1];
  chan_t              ch_q   [NUM_STG+1][NUM_CH];
  chan_t              ch_d   [NUM_STG+1][NUM_CH];
  logic [OUT_W-1:0]   out_q;
  logic               out_vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_in
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    assign sum  = s_axis_tdata[c*SUM_W +: SUM_W];
    assign prod = PROD_W'(sum) * PROD_W'(FULL_SCALE_SQ);
    always_comb begin
      ch_d[0][c].rhs = prod[PROD_W-1:SUM_FRAC_BITS];
      ch_d[0][c].sq  = '0;
      ch_d[0][c].k   = '0;
    end
  end

  for (genvar j = 0; j < NUM_STG; j++) begin : g_stg
    localparam int unsigned B = NUM_STG - 1 - j;
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
      logic [SQ_W-1:0]          tsq;
      logic [SQ_W+CNT_W-1:0]    p;
      logic                     take;
      always_comb begin
        tsq  = ch_q[j][c].sq + (SQ_W'(ch_q[j][c].k) << (B + 1)) + (SQ_W'(1) << (2 * B));
        p    = (SQ_W+CNT_W)'(tsq) * (SQ_W+CNT_W)'(cnt_q[j]);
        take = PROD_W'(p) <= PROD_W'(ch_q[j][c].rhs);
        ch_d[j+1][c].rhs = ch_q[j][c].rhs;
        ch_d[j+1][c].sq  = take ? tsq : ch_q[j][c].sq;
        ch_d[j+1][c].k   = take ? (ch_q[j][c].k | (BYTE_W'(1) << B)) : ch_q[j][c].k;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NUM_STG; i++) vld_q[i] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i <= NUM_STG; i++) vld_q[i] <= vld_q[i-1];
      out_vld_q <= vld_q[NUM_STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnt_q[0]  <= s_axis_tdata[3*SUM_W +: CNT_W];
      zero_q[0] <= s_axis_tdata[3*SUM_W +: CNT_W] == '0;
      for (int i = 1; i <= NUM_STG; i++) begin
        cnt_q[i]  <= cnt_q[i-1];
        zero_q[i] <= zero_q[i-1];
      end
      for (int i = 0; i <= NUM_STG; i++) begin
        for (int c = 0; c < NUM_CH; c++) ch_q[i][c] <= ch_d[i][c];
      end
      for (int c = 0; c < NUM_CH; c++) begin
        out_q[c*BYTE_W +: BYTE_W] <= zero_q[NUM_STG] ? '0 : ch_q[NUM_STG][c].k;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/apr_checker.sv @@
// port checker for the pixel resolve block and its bind
`default_nettype none
`include "accumulated_pixel_resolve_assert.svh"
module apr_checker import apr_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [IN_W-1:0]  s_axis_tdata,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);
  `APR_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `APR_ASSERT_IMP(a_ready, clk_i, rst_ni, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `APR_ASSERT_IMP(a_rst, clk_i, rst_ni, !$past(rst_ni), !m_axis_tvalid)
endmodule

bind accumulated_pixel_resolve apr_checker u_apr_checker (.*);
`default_nettype wire

@@ sim/accumulated_pixel_resolve_tb.sv @@
// testbench for the pixel resolve block: directed and random pixels against a local predictor
`default_nettype none
module accumulated_pixel_resolve_tb;
  import apr_pkg::*;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  rgb_t pixel_q[$];
  int   fail_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  accumulated_pixel_resolve dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // largest k with k*k*count*2^frac <= 65025*sum
  function automatic logic [7:0] gamma_byte(logic [31:0] sum, logic [15:0] cnt);
    logic [63:0] rhs;
    logic [63:0] den;
    logic [63:0] trial;
    logic [7:0]  k;
    rhs = 64'(sum) * 64'd65025;
    den = 64'(cnt) << SUM_FRAC_BITS;
    k = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      trial = 64'(k | (8'd1 << b));
      if (trial * trial * den <= rhs) k = k | (8'd1 << b);
    end
    return k;
  endfunction

  function automatic rgb_t resolve_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                         logic [15:0] cnt);
    rgb_t p;
    p = '0;
    if (cnt != 0) begin
      p.red = gamma_byte(r, cnt);
      p.green = gamma_byte(g, cnt);
      p.blue = gamma_byte(b, cnt);
    end
    return p;
  endfunction

  task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b, logic [15:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {cnt, b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    pixel_q.push_back(resolve_pixel(r, g, b, cnt));
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected transaction %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          rgb_t e;
          rgb_t a;
          e = pixel_q.pop_front();
          a = m_axis_tdata;
          if (a.red !== e.red) begin
            $error("out_red expected %0d actual %0d", e.red, a.red); fail_cnt++;
          end
          if (a.green !== e.green) begin
            $error("out_green expected %0d actual %0d", e.green, a.green); fail_cnt++;
          end
          if (a.blue !== e.blue) begin
            $error("out_blue expected %0d actual %0d", e.blue, a.blue); fail_cnt++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_sum(logic [15:0] cnt);
    logic [47:0] full;
    case ($urandom_range(3))
      0: return $urandom();
      1: begin
        // mean near one
        full = (48'(cnt) << SUM_FRAC_BITS);
        full = full + 48'($signed($urandom_range(2000)) - 1000);
        return (full > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : full[31:0];
      end
      2: begin
        full = (48'(cnt) << SUM_FRAC_BITS) * $urandom_range(1000) / 1000;
        return (full > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : full[31:0];
      end
      default: return 32'($urandom_range(65535)) >> $urandom_range(16);
    endcase
  endfunction

  task automatic test_directed();
    send_pixel(32'h0, 32'h0, 32'h0, 16'd0);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    send_pixel(32'h0, 32'h0, 32'h0, 16'd1);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
    send_pixel(32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 16'hFFFF);
    send_pixel(32'h0001_0000, 32'h0000_FFFF, 32'h0001_0001, 16'd1);
    send_pixel(32'h0000_4000, 32'h0000_0001, 32'h5555_AAAA, 16'd1);
    send_pixel(32'hFFFF_0000, 32'hFFFE_FFFF, 32'hFFFF_0001, 16'hFFFF);
    send_pixel(32'h0000_8000, 32'h0001_0000, 32'h0002_0000, 16'd2);
    send_pixel(32'hAAAA_5555, 32'h5555_AAAA, 32'h0, 16'h8000);
    send_pixel(32'h1234_5678, 32'h0, 32'h0000_0100, 16'h5555);
    send_pixel(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 16'hAAAA);
    go_idle();
  endtask

  task automatic test_random(int n);
    logic [15:0] cnt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: cnt = 16'd0;
        1: cnt = 16'hFFFF - 16'($urandom_range(3));
        2, 3: cnt = 16'($urandom());
        default: cnt = 16'($urandom_range(1, 64));
      endcase
      send_pixel(rand_sum(cnt), rand_sum(cnt), rand_sum(cnt), cnt);
    end
    go_idle();
  endtask

  task automatic drain();
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(500);
    send_idle_pct = 60; recv_stall_pct = 0;  test_random(480);
    send_idle_pct = 0;  recv_stall_pct = 60; test_random(480);
    send_idle_pct = 24; recv_stall_pct = 24; test_random(480);
    drain();
    if (fail_cnt == 0 && pixel_q.size() == 0) begin
      $display("accumulated_pixel_resolve: match");
    end else begin
      $display("accumulated_pixel_resolve: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("accumulated_pixel_resolve: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/apr_pkg.sv
rtl/core/accumulated_pixel_resolve.sv
rtl/core/apr_checker.sv
sim/accumulated_pixel_resolve_tb.sv
